>>> hdl/ssr_pkg.sv
`timescale 1ns / 1ps
package ssr_pkg;

   // Fixed widths of the stream and the register port.
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 4;
   localparam int DATA_W = 64;
   localparam int ADDR_W = 5;

   // Default pattern bounds.
   localparam int MAX_SEARCH_DEF  = 8;
   localparam int MAX_REPLACE_DEF = 8;

   // Register indexes, taken from paddr[4:3].
   typedef enum logic [1:0] {
      REG_SEARCH_PAT = 2'd0,
      REG_SEARCH_LEN = 2'd1,
      REG_REPL_PAT   = 2'd2,
      REG_REPL_LEN   = 2'd3
   } reg_index_type;

   // Control of one window cell.
   typedef struct packed {
      logic load;     // a beat is accepted: the cell takes its next value
      logic append;   // the incoming byte lands in this cell
      logic shift;    // the cell takes the byte from further up the row
   } win_ctl_type;

   // Control of one output cell.
   typedef struct packed {
      logic load;     // parallel load of a new burst
      logic pop;      // the head moved out: shift toward the head
   } out_ctl_type;

endpackage

>>> hdl/ssr_win_cell.sv
`timescale 1ns / 1ps
module ssr_win_cell (
   input  logic                       clock,
   input  ssr_pkg::win_ctl_type       ctl,
   input  logic [ssr_pkg::BYTE_W-1:0] in_byte,
   input  logic [ssr_pkg::BYTE_W-1:0] src_byte,
   input  logic [ssr_pkg::BYTE_W-1:0] pat_byte,
   output logic [ssr_pkg::BYTE_W-1:0] cur_byte,
   output logic                       eq
);
   import ssr_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   // The window content after the incoming byte is placed.
   assign cur_byte = ctl.append ? in_byte : byte_ff;
   assign eq       = (cur_byte == pat_byte);

   // Either keep the byte or take the one handed down the row.
   assign byte_in = ctl.shift ? src_byte : cur_byte;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         byte_ff <= byte_in;
      end
   end

endmodule

>>> hdl/ssr_out_cell.sv
`timescale 1ns / 1ps
module ssr_out_cell (
   input  logic                       clock,
   input  ssr_pkg::out_ctl_type       ctl,
   input  logic [ssr_pkg::BYTE_W-1:0] load_byte,
   input  logic [ssr_pkg::BYTE_W-1:0] next_byte,
   output logic [ssr_pkg::BYTE_W-1:0] held_byte
);
   import ssr_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   // A new burst wins over the shift toward the head.
   always_comb begin
      if (ctl.load) begin
         byte_in = load_byte;
      end else if (ctl.pop) begin
         byte_in = next_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign held_byte = byte_ff;

endmodule

>>> hdl/stream_substring_replace.sv
`timescale 1ns / 1ps
// Path: an accepted beat loads the output cell row; its first result then moves from the
// row's head into the output register. Throughput: a beat that yields at most one result is
// taken every cycle while the result channel does not stall; a beat that yields more holds
// the input while the output cell row drains. Reset: synchronous, active high; clears the
// configuration registers, the window fill and the burst count. No clearing pass is needed.
module stream_substring_replace #(
   parameter int MAX_SEARCH  = ssr_pkg::MAX_SEARCH_DEF,
   parameter int MAX_REPLACE = ssr_pkg::MAX_REPLACE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // Input channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ssr_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                       req_is_final,
   // Result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ssr_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_byte_valid,
   output logic                       rsp_string_end,
   output logic                       rsp_run_end,
   // Register port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ssr_pkg::ADDR_W-1:0] paddr,
   input  logic [ssr_pkg::DATA_W-1:0] pwdata,
   output logic [ssr_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import ssr_pkg::*;

   localparam int WIN_D   = MAX_SEARCH;
   localparam int BURST_D = (MAX_SEARCH > MAX_REPLACE) ? MAX_SEARCH : MAX_REPLACE;
   localparam int FILL_W  = $clog2(MAX_SEARCH + 1);
   localparam int CNT_W   = $clog2(BURST_D + 1);

   // Configuration registers.
   logic [DATA_W-1:0] search_pat_ff;
   logic [LEN_W-1:0]  search_len_ff;
   logic [DATA_W-1:0] repl_pat_ff;
   logic [LEN_W-1:0]  repl_len_ff;
   reg_index_type     reg_index;
   logic              reg_write;

   // Window state.
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;

   // Burst and output state.
   logic [CNT_W-1:0]  burst_cnt_ff;
   logic [CNT_W-1:0]  burst_cnt_in;
   logic              burst_fin_ff;
   logic              burst_bare_ff;
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_bvalid_ff;
   logic              rsp_send_ff;
   logic              rsp_rend_ff;

   // Step decode.
   logic              accept;
   logic              pop;
   logic [FILL_W-1:0] slen;
   logic [CNT_W-1:0]  rlen;
   logic [FILL_W-1:0] fill1;
   logic [FILL_W-1:0] keep;
   logic [FILL_W-1:0] shift_amt;
   logic [CNT_W-1:0]  emit_n;
   logic [CNT_W-1:0]  burst_n;
   logic              cmp;
   logic              match_all;
   logic              is_match;
   logic              bare;
   logic              do_shift;

   logic [BYTE_W-1:0] cur_byte [WIN_D];
   logic [BYTE_W-1:0] src_byte [WIN_D];
   logic              eq       [WIN_D];
   win_ctl_type       win_ctl  [WIN_D];
   logic [BYTE_W-1:0] load_byte [BURST_D];
   logic [BYTE_W-1:0] held_byte [BURST_D];
   out_ctl_type       out_ctl;

   // Register port: writes on the access phase, reads are combinational.
   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[4:3]);
   assign reg_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         search_pat_ff <= '0;
         search_len_ff <= '0;
         repl_pat_ff   <= '0;
         repl_len_ff   <= '0;
      end else if (reg_write) begin
         unique case (reg_index)
            REG_SEARCH_PAT: search_pat_ff <= pwdata;
            REG_SEARCH_LEN: search_len_ff <= pwdata[LEN_W-1:0];
            REG_REPL_PAT:   repl_pat_ff   <= pwdata;
            REG_REPL_LEN:   repl_len_ff   <= pwdata[LEN_W-1:0];
            default:        search_pat_ff <= search_pat_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_SEARCH_PAT: prdata = search_pat_ff;
         REG_SEARCH_LEN: prdata = DATA_W'(search_len_ff);
         REG_REPL_PAT:   prdata = repl_pat_ff;
         REG_REPL_LEN:   prdata = DATA_W'(repl_len_ff);
         default:        prdata = '0;
      endcase
   end

   // Pattern lengths saturate at the configured bounds.
   assign slen = (search_len_ff > LEN_W'(MAX_SEARCH)) ? FILL_W'(MAX_SEARCH)
                                                      : FILL_W'(search_len_ff);
   assign rlen = (repl_len_ff > LEN_W'(MAX_REPLACE)) ? CNT_W'(MAX_REPLACE)
                                                     : CNT_W'(repl_len_ff);

   // Handshakes: a new beat enters once the burst row is empty or empties now.
   assign pop       = (burst_cnt_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (burst_cnt_ff == '0) || ((burst_cnt_ff == CNT_W'(1)) && pop);
   assign accept    = req_valid && req_ready;

   // Row of window cells.
   for (genvar i = 0; i < WIN_D; i++) begin : g_win
      always_comb begin
         win_ctl[i].load   = accept;
         win_ctl[i].append = (fill_ff == FILL_W'(i));
         win_ctl[i].shift  = do_shift;
      end

      // Byte that moves down to this cell when the oldest bytes leave.
      always_comb begin
         src_byte[i] = '0;
         for (int j = 0; j < WIN_D; j++) begin
            if (j == i + int'(shift_amt)) begin
               src_byte[i] = cur_byte[j];
            end
         end
      end

      ssr_win_cell u_cell (
         .clock    (clock),
         .ctl      (win_ctl[i]),
         .in_byte  (req_in_byte),
         .src_byte (src_byte[i]),
         .pat_byte (search_pat_ff[BYTE_W*i +: BYTE_W]),
         .cur_byte (cur_byte[i]),
         .eq       (eq[i])
      );
   end

   // Match over the cells that the search length covers.
   always_comb begin
      match_all = 1'b1;
      for (int i = 0; i < WIN_D; i++) begin
         if ((FILL_W'(i) < slen) && !eq[i]) begin
            match_all = 1'b0;
         end
      end
   end

   // Decide how many bytes leave and how many stay in the window.
   always_comb begin
      fill1    = fill_ff + FILL_W'(1);
      cmp      = (slen != '0) && (fill1 == slen);
      is_match = cmp && match_all;
      if (is_match) begin
         keep = '0;
      end else if (cmp) begin
         keep = fill1 - FILL_W'(1);
      end else if (fill1 > slen) begin
         keep = (slen != '0) ? slen - FILL_W'(1) : '0;
      end else begin
         keep = fill1;
      end
      if (req_is_final) begin
         keep = '0;
      end
      shift_amt = fill1 - keep;
      do_shift  = (keep != '0) && (shift_amt != '0);
      emit_n    = is_match ? rlen : CNT_W'(shift_amt);
      bare      = req_is_final && (emit_n == '0);
      burst_n   = bare ? CNT_W'(1) : emit_n;
      fill_in   = accept ? keep : fill_ff;
   end

   // Row of output cells: parallel load of the burst, then drain at the head.
   assign out_ctl.load = accept;
   assign out_ctl.pop  = pop;

   for (genvar j = 0; j < BURST_D; j++) begin : g_out
      logic [BYTE_W-1:0] repl_b;
      logic [BYTE_W-1:0] win_b;
      logic [BYTE_W-1:0] next_b;

      if (j < MAX_REPLACE) begin : g_rep
         assign repl_b = repl_pat_ff[BYTE_W*j +: BYTE_W];
      end else begin : g_norep
         assign repl_b = '0;
      end

      if (j < WIN_D) begin : g_wb
         assign win_b = cur_byte[j];
      end else begin : g_nowb
         assign win_b = '0;
      end

      if (j + 1 < BURST_D) begin : g_nxt
         assign next_b = held_byte[j+1];
      end else begin : g_last
         assign next_b = '0;
      end

      assign load_byte[j] = is_match ? repl_b : win_b;

      ssr_out_cell u_cell (
         .clock     (clock),
         .ctl       (out_ctl),
         .load_byte (load_byte[j]),
         .next_byte (next_b),
         .held_byte (held_byte[j])
      );
   end

   // Burst count: a new burst replaces the one that just finished.
   always_comb begin
      if (accept) begin
         burst_cnt_in = burst_n;
      end else if (pop) begin
         burst_cnt_in = burst_cnt_ff - CNT_W'(1);
      end else begin
         burst_cnt_in = burst_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         burst_cnt_ff  <= '0;
         burst_fin_ff  <= 1'b0;
         burst_bare_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         burst_cnt_ff <= burst_cnt_in;
         if (accept) begin
            burst_fin_ff  <= req_is_final;
            burst_bare_ff <= bare;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output register: one beat from the head of the burst row.
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_byte_ff   <= burst_bare_ff ? '0 : held_byte[0];
         rsp_bvalid_ff <= !burst_bare_ff;
         rsp_rend_ff   <= (burst_cnt_ff == CNT_W'(1));
         rsp_send_ff   <= (burst_cnt_ff == CNT_W'(1)) && burst_fin_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bvalid_ff;
   assign rsp_string_end = rsp_send_ff;
   assign rsp_run_end    = rsp_rend_ff;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import ssr_pkg::*;

   localparam int MAX_SEARCH   = MAX_SEARCH_DEF;
   localparam int MAX_REPLACE  = MAX_REPLACE_DEF;
   localparam int WIN_DEPTH    = 8;
   localparam int RANDOM_ITEMS = 240;
   localparam int CALM_ITEMS   = 40;
   localparam int HOLD_AT      = 100;
   localparam int HOLD_CYCLES  = 150;

   typedef struct {
      logic [BYTE_W-1:0] in_byte;
      logic              is_final;
   } source_byte_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              string_end;
      logic              run_end;
   } rewrite_result_type;

   // Block ports.
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [BYTE_W-1:0] req_in_byte = '0;
   logic              req_is_final = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_byte_valid;
   logic              rsp_string_end;
   logic              rsp_run_end;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // Shadow copy of the configuration and of the pending window.
   logic [63:0]       search_pat = '0;
   logic [3:0]        search_len = '0;
   logic [63:0]       repl_pat = '0;
   logic [3:0]        repl_len = '0;
   logic [7:0]        win_bytes [WIN_DEPTH];
   int                win_fill = 0;

   // Bytes waiting to be offered and rewritten bytes waiting to be seen.
   source_byte_type      source_q [$];
   rewrite_result_type   rewritten_q [$];
   rewrite_result_type   burst_q [$];

   int                bytes_queued = 0;
   int                bytes_accepted = 0;
   int                mismatches = 0;
   int                send_gap = 0;
   int                recv_gap = 0;
   int                hold_left = 0;
   bit                hold_done = 0;
   bit                calm = 0;
   logic [7:0]        alpha [3];
   source_byte_type      next_item;
   rewrite_result_type   want;

   stream_substring_replace dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_is_final   (req_is_final),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_string_end (rsp_string_end),
      .rsp_run_end    (rsp_run_end),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #10 clock = ~clock;

   // Move the oldest window byte out unmatched.
   function automatic void emit_oldest();
      if (win_fill == 0) return;
      burst_q.push_back('{out_byte: win_bytes[0], byte_valid: 1'b1,
                          string_end: 1'b0, run_end: 1'b0});
      for (int i = 0; i < WIN_DEPTH - 1; i++) win_bytes[i] = win_bytes[i + 1];
      win_bytes[WIN_DEPTH - 1] = '0;
      win_fill--;
   endfunction

   // Work out the rewritten bytes that one accepted source byte causes.
   function automatic void rewrite_byte(input logic [7:0] b, input logic fin);
      int slen;
      int rlen;
      int keep;
      bit hit;
      slen = (search_len > MAX_SEARCH) ? MAX_SEARCH : int'(search_len);
      rlen = (repl_len > MAX_REPLACE) ? MAX_REPLACE : int'(repl_len);
      burst_q.delete();
      if (win_fill < WIN_DEPTH) begin
         win_bytes[win_fill] = b;
         win_fill++;
      end
      if (slen > 0 && win_fill == slen) begin
         hit = 1'b1;
         for (int i = 0; i < slen; i++)
            if (win_bytes[i] != search_pat[8*i +: 8]) hit = 1'b0;
         if (hit) begin
            for (int i = 0; i < rlen; i++)
               burst_q.push_back('{out_byte: repl_pat[8*i +: 8], byte_valid: 1'b1,
                                   string_end: 1'b0, run_end: 1'b0});
            for (int i = 0; i < WIN_DEPTH; i++) win_bytes[i] = '0;
            win_fill = 0;
         end else begin
            emit_oldest();
         end
      end else if (win_fill > slen) begin
         // The search length shrank below the window contents.
         keep = (slen > 0) ? slen - 1 : 0;
         while (win_fill > keep) emit_oldest();
      end
      if (fin) begin
         while (win_fill > 0) emit_oldest();
         if (burst_q.size() == 0)
            burst_q.push_back('{out_byte: 8'h00, byte_valid: 1'b0,
                                string_end: 1'b0, run_end: 1'b0});
         burst_q[burst_q.size() - 1].string_end = 1'b1;
      end
      if (burst_q.size() > 0) burst_q[burst_q.size() - 1].run_end = 1'b1;
      foreach (burst_q[i]) rewritten_q.push_back(burst_q[i]);
   endfunction

   function automatic void check_field(input string name, input logic [7:0] exp_val,
                                       input logic [7:0] got_val);
      if (got_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, got_val);
         mismatches++;
      end
   endfunction

   // Driver: offers source bytes from the queue, with random gaps between beats.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            rewrite_byte(req_in_byte, req_is_final);
            bytes_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap--;
            end else if (source_q.size() > 0) begin
               next_item = source_q.pop_front();
               req_valid <= 1'b1;
               req_in_byte <= next_item.in_byte;
               req_is_final <= next_item.is_final;
               if (!calm && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result beat and applies receiver back-pressure.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (rewritten_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual byte %h valid %b end %b/%b",
                     $time, rsp_out_byte, rsp_byte_valid, rsp_string_end, rsp_run_end);
            mismatches++;
         end else begin
            want = rewritten_q.pop_front();
            check_field("out_byte", want.out_byte, rsp_out_byte);
            check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_byte_valid));
            check_field("string_end", 8'(want.string_end), 8'(rsp_string_end));
            check_field("run_end", 8'(want.run_end), 8'(rsp_run_end));
         end
      end
      // One long hold-off lets the block fill up and stall its input.
      if (!hold_done && bytes_accepted >= HOLD_AT) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (recv_gap > 0) begin
         rsp_ready <= 1'b0;
         recv_gap--;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 3);
      end
   end

   // Register write: setup cycle, then access cycle; the shadow copy follows.
   task automatic write_csr(input reg_index_type idx, input logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_SEARCH_PAT: search_pat = value;
         REG_SEARCH_LEN: search_len = value[3:0];
         REG_REPL_PAT:   repl_pat = value;
         REG_REPL_LEN:   repl_len = value[3:0];
      endcase
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_patterns(input logic [63:0] sp, input logic [3:0] sl,
                               input logic [63:0] rp, input logic [3:0] rl);
      write_csr(REG_SEARCH_PAT, sp);
      write_csr(REG_SEARCH_LEN, 64'(sl));
      write_csr(REG_REPL_PAT, rp);
      write_csr(REG_REPL_LEN, 64'(rl));
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic fin);
      source_q.push_back('{in_byte: b, is_final: fin});
      bytes_queued++;
   endtask

   // Queue up to eight bytes, first in the low octet.
   task automatic send_bytes(input logic [63:0] bytes, input int count, input bit ends);
      for (int i = 0; i < count; i++) queue_byte(bytes[8*i +: 8], ends && i == count - 1);
   endtask

   // Wait until every accepted byte has produced its results, then some settling.
   task automatic wait_idle();
      while (bytes_accepted != bytes_queued || rewritten_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic randomize_patterns();
      logic [63:0] sp;
      logic [63:0] rp;
      logic [3:0]  sl;
      logic [3:0]  rl;
      int          eff;
      for (int i = 0; i < 3; i++) alpha[i] = 8'($urandom_range(1, 255));
      case ($urandom_range(0, 5))
         0: sl = 4'd0;
         1: sl = 4'd8;
         2: sl = 4'($urandom_range(9, 15));
         default: sl = 4'($urandom_range(1, 7));
      endcase
      case ($urandom_range(0, 5))
         0: rl = 4'd0;
         1: rl = 4'd8;
         2: rl = 4'($urandom_range(9, 15));
         default: rl = 4'($urandom_range(1, 7));
      endcase
      sp = {$urandom, $urandom};
      rp = {$urandom, $urandom};
      eff = (sl > MAX_SEARCH) ? MAX_SEARCH : int'(sl);
      // Pattern bytes come from a small alphabet so that partial matches are common.
      for (int i = 0; i < eff; i++) sp[8*i +: 8] = alpha[$urandom_range(0, 2)];
      set_patterns(sp, sl, rp, rl);
   endtask

   // A string built mostly from whole occurrences of the pattern and alphabet bytes.
   task automatic queue_random_string(input bit leave_open, output int n);
      int chunks;
      int eff;
      chunks = $urandom_range(1, 4);
      eff = (search_len > MAX_SEARCH) ? MAX_SEARCH : int'(search_len);
      n = 0;
      for (int c = 0; c < chunks; c++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               if (eff == 0) begin
                  queue_byte(alpha[$urandom_range(0, 2)], 1'b0);
                  n++;
               end
               for (int i = 0; i < eff; i++) begin
                  queue_byte(search_pat[8*i +: 8], 1'b0);
                  n++;
               end
            end
            9: begin
               queue_byte(8'($urandom_range(1, 255)), 1'b0);
               n++;
            end
            default: begin
               queue_byte(alpha[$urandom_range(0, 2)], 1'b0);
               n++;
            end
         endcase
      end
      // No time passes here, so the last byte is still in the queue.
      if (!leave_open) source_q[source_q.size() - 1].is_final = 1'b1;
   endtask

   // Run limit.
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Stimulus sequence.
   initial begin
      int random_items;
      int phase_items;
      int phase_target;
      int n;
      for (int i = 0; i < WIN_DEPTH; i++) win_bytes[i] = '0;
      random_items = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Pass-through after reset, extreme byte values.
      send_bytes(64'h7F80_FF01, 4, 1'b1);
      wait_idle();

      // Three-byte search, two-byte replacement, a match and a partial match.
      set_patterns(64'h0063_6261, 4'd3, 64'h5958, 4'd2);
      send_bytes(64'h007A_6261_6362_6178, 7, 1'b1);
      wait_idle();

      // Deleting replacement: the final byte completes a match, so a bare end marker.
      set_patterns(64'h6261, 4'd2, 64'h0, 4'd0);
      send_bytes(64'h6261, 2, 1'b1);
      wait_idle();

      // Lengths above the bound saturate; full-width match emits eight bytes, one zero.
      set_patterns(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h00FF_0102_0304_0580, 4'd12);
      send_bytes(64'hFFFF_FFFF_FFFF_FFFF, 8, 1'b1);
      wait_idle();

      // The search length shrinks while the window holds three bytes.
      send_bytes(64'h01_FFFF, 3, 1'b0);
      wait_idle();
      write_csr(REG_SEARCH_LEN, 64'd2);
      send_bytes(64'h01, 1, 1'b1);
      wait_idle();

      // Random phases: a fresh setting, then strings; some phases end mid-string.
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         randomize_patterns();
         phase_items = 0;
         phase_target = $urandom_range(15, 40);
         while (phase_items < phase_target) begin
            queue_random_string(1'b0, n);
            phase_items += n;
         end
         if ($urandom_range(0, 2) == 0) begin
            queue_random_string(1'b1, n);
            phase_items += n;
         end
         random_items += phase_items;
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && rewritten_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
